// ===== design/cgbm_pkg.sv =====
// shared types, constants and functions for the correlated gbm path step block
package cgbm_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumRegs  = 7;

  localparam logic [2:0] REG_SPOT  = 3'd0;
  localparam logic [2:0] REG_DRIFT = 3'd1;
  localparam logic [2:0] REG_ROW0  = 3'd2;
  localparam logic [2:0] REG_ROW1  = 3'd3;
  localparam logic [2:0] REG_ROW2  = 3'd4;
  localparam logic [2:0] REG_ROW3  = 3'd5;
  localparam logic [2:0] REG_STEPS = 3'd6;

  localparam logic [29:0] LOG2E_Q28 = 30'd387270501;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

  // ceil(2^34 / k), exact quotient for any 31-bit dividend
  localparam logic [32:0] RECIP3 = 33'd5726623062;
  localparam logic [32:0] RECIP5 = 33'd3435973837;
  localparam logic [32:0] RECIP6 = 33'd2863311531;
  localparam logic [32:0] RECIP7 = 33'd2454267027;

  // queue entry: samples of one step plus path bookkeeping
  typedef struct packed {
    logic signed [15:0] g0;
    logic signed [15:0] g1;
    logic signed [15:0] g2;
    logic signed [15:0] g3;
    logic               path_start;
    logic [15:0]        step_index;
    logic               path_end;
  } cgbm_job_t;

  // horner stage: floor(q / k) for k in 1..8, by shift or reciprocal multiply
  function automatic logic [30:0] horner_div(input logic [30:0] q,
                                             input logic [3:0] k);
    logic [32:0] recip;
    logic [63:0] prod;
    begin
      case (k)
        4'd7:    recip = RECIP7;
        4'd6:    recip = RECIP6;
        4'd5:    recip = RECIP5;
        4'd3:    recip = RECIP3;
        default: recip = '0;
      endcase
      prod = {33'd0, q} * {31'd0, recip};
      case (k)
        4'd8:    horner_div = q >> 3;
        4'd4:    horner_div = q >> 2;
        4'd2:    horner_div = q >> 1;
        4'd1:    horner_div = q;
        default: horner_div = {1'b0, prod[63:34]};
      endcase
    end
  endfunction

endpackage

// ===== design/correlated_gbm_path_step_top.sv =====
// top level of the correlated gbm path step block
// One input word carries four Q4.12 normal samples for one timestep; one output
// word carries the four new Q16.16 prices and the step number, with the path end
// flag in tlast. A front stage keeps the step counter and places each word in a
// two-entry queue; the back stage works one item at a time, one asset after
// another: per asset j it runs the correlated sum over terms 0..j, the log2(e)
// scale, the fraction, the Horner loop for exp (a multiply and a divide, by shift
// or reciprocal multiply, for each of the eight terms), one price multiply and
// one shift/saturate step. A stalled output holds the finished item, and the queue
// holds two more words meanwhile. Prices reload from spot at each path start.
module correlated_gbm_path_step_top #(
  parameter int unsigned ASSETS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // sample_0, sample_1, sample_2, sample_3
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // asset0..3_price, step_index
  output logic         out_tlast,  // path_end
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] spot_r, drift_r, row0_r, row1_r, row2_r, row3_r;
  logic [15:0] steps_r;

  // configuration registers, out-of-range writes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r <= '0; drift_r <= '0; row0_r <= '0; row1_r <= '0;
      row2_r <= '0; row3_r <= '0; steps_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cgbm_pkg::REG_SPOT:  spot_r  <= cfg_data;
        cgbm_pkg::REG_DRIFT: drift_r <= cfg_data;
        cgbm_pkg::REG_ROW0:  row0_r  <= cfg_data;
        cgbm_pkg::REG_ROW1:  row1_r  <= cfg_data;
        cgbm_pkg::REG_ROW2:  row2_r  <= cfg_data;
        cgbm_pkg::REG_ROW3:  row3_r  <= cfg_data;
        cgbm_pkg::REG_STEPS: steps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  cgbm_pkg::cgbm_job_t fq_job, qb_job;
  logic fq_valid, fq_ready, qb_valid, qb_ready;

  cgbm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .steps_per_path(steps_r),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  cgbm_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  cgbm_back #(.ASSETS(ASSETS)) u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .spot_prices(spot_r), .drift_terms(drift_r),
    .coef_row_0(row0_r), .coef_row_1(row1_r),
    .coef_row_2(row2_r), .coef_row_3(row3_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// ===== design/cgbm_front.sv =====
// front part: step counting, path bookkeeping and job formation
module cgbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic [15:0]         steps_per_path,
  output logic                job_valid,
  input  logic                job_ready,
  output cgbm_pkg::cgbm_job_t job
);

  logic [15:0] step_count_r, step_count_nxt;
  logic [15:0] steps_eff;
  logic [15:0] step_inc;
  logic        last_step;

  assign steps_eff = (steps_per_path == 16'd0) ? 16'd1 : steps_per_path;
  assign step_inc  = step_count_r + 16'd1;
  assign last_step = (step_inc >= steps_eff) || (step_inc == 16'd0);

  assign in_tready = job_ready;
  assign job_valid = in_tvalid;

  always_comb begin
    job.g0         = in_tdata[15:0];
    job.g1         = in_tdata[31:16];
    job.g2         = in_tdata[47:32];
    job.g3         = in_tdata[63:48];
    job.path_start = (step_count_r == 16'd0);
    job.step_index = step_inc;
    job.path_end   = last_step;
    step_count_nxt = step_count_r;
    if (in_tvalid && job_ready) begin
      step_count_nxt = last_step ? 16'd0 : step_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
    end else begin
      step_count_r <= step_count_nxt;
    end
  end

endmodule

// ===== design/cgbm_queue.sv =====
// two-entry queue between front and back
module cgbm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  cgbm_pkg::cgbm_job_t wr_job,
  output logic                rd_valid,
  input  logic                rd_ready,
  output cgbm_pkg::cgbm_job_t rd_job
);

  cgbm_pkg::cgbm_job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue count overflow");

endmodule

// ===== design/cgbm_back.sv =====
// back part: sequential per-asset correlated sum, exp and price update
module cgbm_back #(
  parameter int unsigned ASSETS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  cgbm_pkg::cgbm_job_t job,
  input  logic [63:0]         spot_prices,
  input  logic [63:0]         drift_terms,
  input  logic [63:0]         coef_row_0,
  input  logic [63:0]         coef_row_1,
  input  logic [63:0]         coef_row_2,
  input  logic [63:0]         coef_row_3,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [143:0]        out_tdata,
  output logic                out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_MUL, ST_FRAC, ST_HORN, ST_HDIV, ST_PMUL, ST_SHIFT, ST_OUT
  } st_t;

  st_t st_r, st_nxt;
  cgbm_pkg::cgbm_job_t job_r;
  logic [1:0]   asset_r, asset_nxt;
  logic [2:0]   term_r, term_nxt;
  logic [3:0]   hk_r, hk_nxt;
  logic signed [35:0] x_r, x_nxt;
  logic signed [67:0] y_r, y_nxt;
  logic [29:0]  t_r, t_nxt;
  logic [30:0]  acc_r, acc_nxt;
  logic [30:0]  q_r, q_nxt;
  logic [62:0]  p_r, p_nxt;
  logic [31:0]  price_r [4];
  logic [31:0]  price_nxt;
  logic         price_we;
  logic         busy_load;

  logic [63:0]        row;
  logic signed [15:0] coef, g;
  logic signed [31:0] cg;
  logic signed [41:0] yfl;
  logic signed [15:0] n_w;
  logic [25:0]        f_w;
  logic [55:0]        tprod;
  logic [60:0]        hprod;
  logic [31:0]        base_price;

  always_comb begin
    case (asset_r)
      2'd0:    row = coef_row_0;
      2'd1:    row = coef_row_1;
      2'd2:    row = coef_row_2;
      default: row = coef_row_3;
    endcase
    case (term_r[1:0])
      2'd0:    g = job_r.g0;
      2'd1:    g = job_r.g1;
      2'd2:    g = job_r.g2;
      default: g = job_r.g3;
    endcase
    coef = row[{term_r[1:0], 4'd0} +: 16];
    cg   = coef * g;
    yfl  = 42'(y_r >>> 28);
    n_w  = 16'(yfl >>> 26);
    f_w  = yfl[25:0];
    tprod = f_w * cgbm_pkg::LN2_Q30;
    hprod = acc_r * t_r;
    base_price = job_r.path_start ? {8'd0, spot_prices[{asset_r, 4'd0} +: 16], 8'd0}
                                  : price_r[asset_r];
  end

  always_comb begin
    st_nxt = st_r; asset_nxt = asset_r; term_nxt = term_r; hk_nxt = hk_r;
    x_nxt = x_r; y_nxt = y_r; t_nxt = t_r; acc_nxt = acc_r; q_nxt = q_r; p_nxt = p_r;
    price_nxt = '0; price_we = 1'b0; busy_load = 1'b0;
    job_ready = 1'b0;
    case (st_r)
      ST_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          busy_load = 1'b1; asset_nxt = 2'd0; term_nxt = 3'd0;
          x_nxt = 36'(signed'(drift_terms[15:0])) <<< 12;
          st_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        x_nxt = x_r + 36'(cg);
        if (term_r[1:0] == asset_r) st_nxt = ST_MUL;
        else term_nxt = term_r + 3'd1;
      end
      ST_MUL: begin
        y_nxt = x_r * $signed({1'b0, cgbm_pkg::LOG2E_Q28});
        st_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        t_nxt = tprod[55:26]; acc_nxt = cgbm_pkg::ONE_Q30; hk_nxt = 4'd8;
        st_nxt = ST_HORN;
      end
      ST_HORN: begin
        q_nxt = hprod[60:30];
        st_nxt = ST_HDIV;
      end
      ST_HDIV: begin
        acc_nxt = cgbm_pkg::ONE_Q30 + cgbm_pkg::horner_div(q_r, hk_r);
        hk_nxt = hk_r - 4'd1;
        if (hk_r == 4'd1) st_nxt = ST_PMUL;
        else st_nxt = ST_HORN;
      end
      ST_PMUL: begin
        p_nxt = base_price * acc_r;
        st_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (p_r == 63'd0) price_nxt = '0;
        else if (n_w < 16'sd30) begin
          if ((16'sd30 - n_w) > 16'sd63) price_nxt = '0;
          else begin
            p_nxt = p_r >> (16'sd30 - n_w);
            price_nxt = (p_nxt > 63'(cgbm_pkg::PRICE_MAX)) ? cgbm_pkg::PRICE_MAX
                                                           : p_nxt[31:0];
          end
        end else if ((n_w - 16'sd30) >= 16'sd32) price_nxt = cgbm_pkg::PRICE_MAX;
        else if (p_r > (63'(cgbm_pkg::PRICE_MAX) >> (n_w - 16'sd30)))
          price_nxt = cgbm_pkg::PRICE_MAX;
        else price_nxt = 32'(p_r << (n_w - 16'sd30));
        price_we = 1'b1;
        if (32'(asset_r) + 1 >= ASSETS) st_nxt = ST_OUT;
        else begin
          asset_nxt = asset_r + 2'd1; term_nxt = 3'd0;
          x_nxt = 36'(signed'(drift_terms[{asset_nxt, 4'd0} +: 16])) <<< 12;
          st_nxt = ST_SUM;
        end
      end
      ST_OUT: begin
        if (out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int i = 0; i < 4; i++) price_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (price_we) price_r[asset_r] <= price_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_load) job_r <= job;
    asset_r <= asset_nxt; term_r <= term_nxt; hk_r <= hk_nxt;
    x_r <= x_nxt; y_r <= y_nxt; t_r <= t_nxt; acc_r <= acc_nxt; q_r <= q_nxt;
    p_r <= p_nxt;
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tlast  = job_r.path_end;
  assign out_tdata  = {job_r.step_index,
                       (ASSETS > 3) ? price_r[3] : 32'd0,
                       (ASSETS > 2) ? price_r[2] : 32'd0,
                       (ASSETS > 1) ? price_r[1] : 32'd0,
                       price_r[0]};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_ready |-> st_r == ST_IDLE)
    else $error("job taken while busy");
  a_horner_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_HORN |-> hk_r != 4'd0)
    else $error("horner count underflow");

endmodule
